// ----- rtl/core/bgd_pkg.sv -----
// shared types, constants and multiplier tables for the bus gain ducker
`timescale 1ns / 1ps

package bgd_pkg;

	localparam int GAIN_FRAC_BITS = 10;
	localparam int GAIN_W         = 12;
	localparam int MULT_W         = 16;

	localparam int MUL_A_W = 12;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_N_W = 26;
	localparam int DIV_D_W = 13;
	localparam int DIV_Q_W = 16;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);
	localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(2 << GAIN_FRAC_BITS);
	localparam logic [10:0]       CTRL_MAX = 11'(1 << GAIN_FRAC_BITS);

	localparam logic [MULT_W-1:0] MULT_ONE = 16'd32768;
	localparam logic [MULT_W-1:0] CMB_COEF = 16'd4915;
	localparam logic [MULT_W-1:0] INT_COEF = 16'd3277;

	localparam logic [8:0] HOLD_RESTART = 9'd400;

	localparam logic [1:0]  MODE_RESET   = 2'd3;
	localparam logic [59:0] BUS_RESET    = 60'd1126037350260736;
	localparam logic [15:0] DEPTH_RESET  = 16'd22938;
	localparam logic [10:0] ATTACK_RESET = 11'd80;
	localparam logic [12:0] RELEASE_RESET = 13'd350;

	localparam logic [2:0] BUS_SFX   = 3'd0;
	localparam logic [2:0] BUS_UI    = 3'd1;
	localparam logic [2:0] BUS_VOICE = 3'd2;
	localparam logic [2:0] BUS_MUSIC = 3'd3;
	localparam logic [2:0] BUS_AMB   = 3'd4;

	localparam logic [1:0] GP_COMBAT = 2'd1;
	localparam logic [1:0] GP_PAUSED = 2'd2;
	localparam logic [1:0] LOC_WATER = 2'd1;
	localparam logic [1:0] LOC_INDOOR = 2'd2;

	typedef enum logic [1:0] {
		CMD_FRAME,
		CMD_SRC,
		CMD_MUSIC,
		CMD_NONE
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_BUS_GAINS,
		REG_DUCK_DEPTH,
		REG_ATTACK,
		REG_RELEASE,
		REG_MIX_STATES,
		REG_INTENSITY,
		REG_COMBAT
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FRAME,
		ST_FMUL,
		ST_FDIV,
		ST_SRC,
		ST_RTPC,
		ST_GP,
		ST_LOC,
		ST_RTM,
		ST_DUCK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	function automatic logic [MULT_W-1:0] gameplay_mult(logic [1:0] code, logic [2:0] bus);
		logic [MULT_W-1:0] m;
		m = MULT_ONE;
		case (code)
			GP_COMBAT: begin
				case (bus)
					BUS_SFX:   m = 16'd36045;
					BUS_MUSIC: m = 16'd31130;
					default:   m = MULT_ONE;
				endcase
			end
			GP_PAUSED: m = '0;
			default:   m = MULT_ONE;
		endcase
		return m;
	endfunction

	function automatic logic [MULT_W-1:0] location_mult(logic [1:0] code, logic [2:0] bus);
		logic [MULT_W-1:0] m;
		m = MULT_ONE;
		case (code)
			LOC_WATER: begin
				case (bus)
					BUS_SFX:   m = 16'd21299;
					BUS_UI:    m = 16'd29491;
					BUS_VOICE: m = 16'd29491;
					BUS_MUSIC: m = 16'd22938;
					BUS_AMB:   m = 16'd16384;
					default:   m = MULT_ONE;
				endcase
			end
			LOC_INDOOR: begin
				case (bus)
					BUS_SFX: m = 16'd31130;
					BUS_AMB: m = 16'd34406;
					default: m = MULT_ONE;
				endcase
			end
			default: m = MULT_ONE;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/core/bgd_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module bgd_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgd_pkg::mul_req_t             req,
	output logic                          done,
	output logic [bgd_pkg::MUL_P_W-1:0]   product
);

	localparam int CW = $clog2(bgd_pkg::MUL_B_W + 1);
	localparam int AW = bgd_pkg::MUL_A_W;
	localparam int BW = bgd_pkg::MUL_B_W;

	logic [bgd_pkg::MUL_P_W-1:0] acc_q;
	logic [AW-1:0]               a_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [AW:0]                 sum;

	assign sum = {1'b0, acc_q[bgd_pkg::MUL_P_W-1:BW]} + (acc_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product register doubles as the multiplier shift line
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= {{AW{1'b0}}, req.b};
			a_q   <= req.a;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[BW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- rtl/core/bgd_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bgd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgd_pkg::div_req_t             req,
	output logic                          done,
	output logic [bgd_pkg::DIV_Q_W-1:0]   quotient
);

	localparam int NW = bgd_pkg::DIV_N_W;
	localparam int DW = bgd_pkg::DIV_D_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[bgd_pkg::DIV_Q_W-1:0];

endmodule

// ----- rtl/core/bus_gain_ducker.sv -----
// bus gain computer with voice-triggered ducking, top level
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser cmd, tdata elapsed_ms + bus
//  m_*      out  m_tvalid/m_tready  tdata gain + duck_level
//  cfg_*    in   cfg_wen            cfg_index, cfg_data
//
//  one item at a time; a serial multiplier and a serial divider set the latency
//  frame: a multiply then a divide, both skipped when the level settles
//  source gain: up to five multiplies, those by 1.0 skipped
//  disabled mixer or unused command: no multiply or divide
//  a finished result waits in the output register while the next item is taken
//  reset clears the duck level and voice hold and loads register defaults
`timescale 1ns / 1ps

module bus_gain_ducker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // elapsed_ms[9:0], bus[12:10], zero fill
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // gain[10:0], duck_level[26:11], zero fill
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data
);

	localparam int GW = bgd_pkg::GAIN_W;
	localparam int MW = bgd_pkg::MULT_W;

	// configuration
	logic [1:0]  mode_q;
	logic [59:0] bus_gains_q;
	logic [15:0] depth_q;
	logic [10:0] attack_q;
	logic [12:0] release_q;
	logic [3:0]  mix_q;
	logic [10:0] intensity_q;
	logic [10:0] combat_q;

	// state and item
	bgd_pkg::state_t state_q, state_d;
	bgd_pkg::cmd_t   cmd_q;
	logic [15:0]     duck_q;
	logic [8:0]      hold_q;
	logic [9:0]      elapsed_q;
	logic [2:0]      bus_q;
	logic [GW-1:0]   g_q;
	logic [MW-1:0]   rtpc_q;
	logic [15:0]     diff_q;
	logic [12:0]     tau_q;
	logic            up_q;
	logic            issued_q;

	// output register
	logic            m_valid_q;
	logic [10:0]     m_gain_q;
	logic [15:0]     m_duck_q;

	// serial units
	bgd_pkg::mul_req_t             mul_req;
	bgd_pkg::div_req_t             div_req;
	logic                          mul_done;
	logic                          div_done;
	logic [bgd_pkg::MUL_P_W-1:0]   mul_prod;
	logic [bgd_pkg::DIV_Q_W-1:0]   div_quo;

	bgd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_prod)
	);

	bgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// frame terms
	logic [8:0]  hold_new;
	logic [15:0] fr_target;
	logic        fr_up;
	logic [12:0] fr_tau_raw;
	logic [12:0] fr_tau;
	logic        fr_reach;
	logic [15:0] fr_diff;

	always_comb begin
		hold_new   = ({1'b0, hold_q} > elapsed_q) ? hold_q - elapsed_q[8:0] : '0;
		fr_target  = (mode_q[1] && hold_new != '0) ? depth_q : '0;
		fr_up      = fr_target > duck_q;
		fr_tau_raw = fr_up ? {2'b0, attack_q} : release_q;
		fr_tau     = (fr_tau_raw == '0) ? 13'd1 : fr_tau_raw;
		fr_reach   = {3'b0, elapsed_q} >= fr_tau;
		fr_diff    = fr_up ? fr_target - duck_q : duck_q - fr_target;
	end

	// gain chain terms
	logic [2:0]    bus_eff;
	logic [GW-1:0] base_raw;
	logic [GW-1:0] base_gain;
	logic [10:0]   ctrl_raw;
	logic [10:0]   ctrl_c;
	logic [MW-1:0] rtpc_new;
	logic [MW-1:0] gp_m;
	logic [MW-1:0] loc_m;
	logic [15:0]   rnd15;
	logic [14:0]   rnd16;
	logic          duck_apply;
	logic [16:0]   duck_inv;
	logic [GW-1:0] g_out;

	always_comb begin
		bus_eff = (cmd_q == bgd_pkg::CMD_MUSIC) ? bgd_pkg::BUS_MUSIC : bus_q;
		case (bus_eff)
			bgd_pkg::BUS_SFX:   base_raw = bus_gains_q[11:0];
			bgd_pkg::BUS_UI:    base_raw = bus_gains_q[23:12];
			bgd_pkg::BUS_VOICE: base_raw = bus_gains_q[35:24];
			bgd_pkg::BUS_MUSIC: base_raw = bus_gains_q[47:36];
			bgd_pkg::BUS_AMB:   base_raw = bus_gains_q[59:48];
			default:            base_raw = bgd_pkg::GAIN_ONE;
		endcase
		base_gain = (base_raw > bgd_pkg::GAIN_MAX) ? bgd_pkg::GAIN_MAX : base_raw;

		ctrl_raw = (bus_q == bgd_pkg::BUS_SFX) ? combat_q : intensity_q;
		ctrl_c   = (ctrl_raw > bgd_pkg::CTRL_MAX) ? bgd_pkg::CTRL_MAX : ctrl_raw;
		rtpc_new = (bus_q == bgd_pkg::BUS_SFX)
			? bgd_pkg::MULT_ONE + {3'b0, mul_prod[22:bgd_pkg::GAIN_FRAC_BITS]}
			: bgd_pkg::MULT_ONE - {3'b0, mul_prod[22:bgd_pkg::GAIN_FRAC_BITS]};

		gp_m  = bgd_pkg::gameplay_mult(mix_q[1:0], bus_q);
		loc_m = bgd_pkg::location_mult(mix_q[3:2], bus_q);

		// round half up: ((p >> (k-1)) + 1) >> 1
		rnd15 = {1'b0, mul_prod[28:14]} + 16'd1;
		rnd16 = {1'b0, mul_prod[28:15]} + 15'd1;

		duck_apply = mode_q[1] && (duck_q != '0) &&
			(cmd_q == bgd_pkg::CMD_MUSIC ||
			 (bus_q != bgd_pkg::BUS_VOICE && bus_q != bgd_pkg::BUS_MUSIC));
		duck_inv = 17'h10000 - {1'b0, duck_q};

		g_out = (g_q > bgd_pkg::GAIN_ONE) ? bgd_pkg::GAIN_ONE : g_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		mul_req.start    = 1'b0;
		mul_req.a        = g_q;
		mul_req.b        = {1'b0, rtpc_q};
		div_req.start    = 1'b0;
		div_req.dividend = mul_prod[bgd_pkg::DIV_N_W-1:0];
		div_req.divisor  = tau_q;
		unique case (state_q)
			bgd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (bgd_pkg::cmd_t'(s_tuser))
						bgd_pkg::CMD_FRAME: state_d = bgd_pkg::ST_FRAME;
						bgd_pkg::CMD_SRC,
						bgd_pkg::CMD_MUSIC: state_d = bgd_pkg::ST_SRC;
						default:            state_d = bgd_pkg::ST_OUT;
					endcase
				end
			end
			bgd_pkg::ST_FRAME: begin
				if (!mode_q[0] || fr_reach) begin
					state_d = bgd_pkg::ST_OUT;
				end else begin
					state_d = bgd_pkg::ST_FMUL;
				end
			end
			bgd_pkg::ST_FMUL: begin
				mul_req.a     = {2'b0, elapsed_q};
				mul_req.b     = {1'b0, diff_q};
				mul_req.start = !issued_q;
				if (mul_done) state_d = bgd_pkg::ST_FDIV;
			end
			bgd_pkg::ST_FDIV: begin
				div_req.start = !issued_q;
				if (div_done) state_d = bgd_pkg::ST_OUT;
			end
			bgd_pkg::ST_SRC: begin
				if (!mode_q[0]) begin
					state_d = bgd_pkg::ST_OUT;
				end else if (bus_eff > bgd_pkg::BUS_AMB) begin
					state_d = bgd_pkg::ST_DUCK;
				end else if (bus_eff == bgd_pkg::BUS_SFX || bus_eff == bgd_pkg::BUS_AMB) begin
					state_d = bgd_pkg::ST_RTPC;
				end else begin
					state_d = bgd_pkg::ST_GP;
				end
			end
			bgd_pkg::ST_RTPC: begin
				mul_req.a     = {1'b0, ctrl_c};
				mul_req.b     = (bus_q == bgd_pkg::BUS_SFX) ? {1'b0, bgd_pkg::CMB_COEF}
				                                           : {1'b0, bgd_pkg::INT_COEF};
				mul_req.start = !issued_q;
				if (mul_done) state_d = bgd_pkg::ST_GP;
			end
			bgd_pkg::ST_GP: begin
				mul_req.b = {1'b0, gp_m};
				if (gp_m == bgd_pkg::MULT_ONE) begin
					state_d = bgd_pkg::ST_LOC;
				end else begin
					mul_req.start = !issued_q;
					if (mul_done) state_d = bgd_pkg::ST_LOC;
				end
			end
			bgd_pkg::ST_LOC: begin
				mul_req.b = {1'b0, loc_m};
				if (loc_m == bgd_pkg::MULT_ONE) begin
					state_d = bgd_pkg::ST_RTM;
				end else begin
					mul_req.start = !issued_q;
					if (mul_done) state_d = bgd_pkg::ST_RTM;
				end
			end
			bgd_pkg::ST_RTM: begin
				if (rtpc_q == bgd_pkg::MULT_ONE) begin
					state_d = bgd_pkg::ST_DUCK;
				end else begin
					mul_req.start = !issued_q;
					if (mul_done) state_d = bgd_pkg::ST_DUCK;
				end
			end
			bgd_pkg::ST_DUCK: begin
				mul_req.b = duck_inv;
				if (!duck_apply) begin
					state_d = bgd_pkg::ST_OUT;
				end else begin
					mul_req.start = !issued_q;
					if (mul_done) state_d = bgd_pkg::ST_OUT;
				end
			end
			bgd_pkg::ST_OUT: begin
				if (!m_valid_q || m_tready) state_d = bgd_pkg::ST_IDLE;
			end
			default: state_d = bgd_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= bgd_pkg::MODE_RESET;
			bus_gains_q <= bgd_pkg::BUS_RESET;
			depth_q     <= bgd_pkg::DEPTH_RESET;
			attack_q    <= bgd_pkg::ATTACK_RESET;
			release_q   <= bgd_pkg::RELEASE_RESET;
			mix_q       <= '0;
			intensity_q <= '0;
			combat_q    <= '0;
			duck_q      <= '0;
			hold_q      <= '0;
			issued_q    <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (bgd_pkg::reg_idx_t'(cfg_index))
					bgd_pkg::REG_MODE:       mode_q      <= cfg_data[1:0];
					bgd_pkg::REG_BUS_GAINS:  bus_gains_q <= cfg_data;
					bgd_pkg::REG_DUCK_DEPTH: depth_q     <= cfg_data[15:0];
					bgd_pkg::REG_ATTACK:     attack_q    <= cfg_data[10:0];
					bgd_pkg::REG_RELEASE:    release_q   <= cfg_data[12:0];
					bgd_pkg::REG_MIX_STATES: mix_q       <= cfg_data[3:0];
					bgd_pkg::REG_INTENSITY:  intensity_q <= cfg_data[10:0];
					bgd_pkg::REG_COMBAT:     combat_q    <= cfg_data[10:0];
					default: ;
				endcase
			end

			if (mul_req.start || div_req.start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end

			if (state_q == bgd_pkg::ST_FRAME) begin
				hold_q <= hold_new;
				if (!mode_q[0]) begin
					duck_q <= '0;
				end else if (fr_reach) begin
					duck_q <= fr_target;
				end
			end
			if (state_q == bgd_pkg::ST_FDIV && div_done) begin
				duck_q <= up_q ? duck_q + div_quo : duck_q - div_quo;
			end
			if (state_q == bgd_pkg::ST_SRC && mode_q[0] &&
			    cmd_q == bgd_pkg::CMD_SRC && bus_q == bgd_pkg::BUS_VOICE) begin
				hold_q <= bgd_pkg::HOLD_RESTART;
			end

			if (state_q == bgd_pkg::ST_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item payload and working registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q     <= bgd_pkg::cmd_t'(s_tuser);
			elapsed_q <= s_tdata[9:0];
			bus_q     <= s_tdata[12:10];
			g_q       <= '0;
		end
		if (state_q == bgd_pkg::ST_FRAME) begin
			diff_q <= fr_diff;
			tau_q  <= fr_tau;
			up_q   <= fr_up;
		end
		if (state_q == bgd_pkg::ST_SRC) begin
			bus_q  <= bus_eff;
			rtpc_q <= bgd_pkg::MULT_ONE;
			g_q    <= mode_q[0] ? base_gain : bgd_pkg::GAIN_ONE;
		end
		if (state_q == bgd_pkg::ST_RTPC && mul_done) rtpc_q <= rtpc_new;
		if (mul_done && (state_q == bgd_pkg::ST_GP || state_q == bgd_pkg::ST_LOC ||
		                 state_q == bgd_pkg::ST_RTM)) begin
			g_q <= rnd15[GW:1];
		end
		if (state_q == bgd_pkg::ST_DUCK && mul_done) g_q <= rnd16[GW:1];
		if (state_q == bgd_pkg::ST_OUT && (!m_valid_q || m_tready)) begin
			m_gain_q <= g_out[10:0];
			m_duck_q <= duck_q;
		end
	end

	assign s_tready = (state_q == bgd_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, m_duck_q, m_gain_q};

endmodule

// ----- rtl/core/bgd_chk.sv -----
// port-level checks for the bus gain ducker, bound to the top level
`timescale 1ns / 1ps

module bgd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// gain never above 1.0
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:0] <= 11'd1024))
		else $error("gain above unity");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while busy");

	// a new result only comes from a busy block
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without work");

endmodule

bind bus_gain_ducker bgd_chk u_bgd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
